@@ rtl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// Poll scheduler package
// Shared widths, codes and record types for the periodic poll scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

   localparam int MAX_CHANNELS_DEF = 64;
   localparam int DEV_W            = 8;
   localparam int KIND_W           = 8;
   localparam int PERIOD_W         = 32;
   localparam int STEP_W           = 16;
   localparam logic [STEP_W-1:0] STEP_RESET = 16'd1000;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_TICK  = 1'b1;
   localparam logic RES_ADD  = 1'b0;
   localparam logic RES_POLL = 1'b1;

   typedef enum logic [1:0] {
      ADD_OK   = 2'd0,
      ADD_FULL = 2'd1,
      ADD_DUP  = 2'd2
   } add_status_type;

   // One table entry
   typedef struct packed {
      logic [DEV_W-1:0]    device;
      logic [KIND_W-1:0]   kind;
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W-1:0] countdown;
   } entry_type;

   // One result transaction
   typedef struct packed {
      logic                result_kind;
      add_status_type      add_status;
      logic [DEV_W-1:0]    request_device;
      logic [KIND_W-1:0]   request_channel;
      logic                group_last;
      logic                tick_last;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ rtl/pps_req_if.sv @@
// ----------------------------------------------------------------------------
// Poll scheduler request channel
// Valid/ready channel carrying add and tick transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface pps_req_if;
   import pps_pkg::*;

   logic                valid;
   logic                ready;
   logic                opcode;
   logic [DEV_W-1:0]    device_id;
   logic [KIND_W-1:0]   channel_kind;
   logic [PERIOD_W-1:0] period_ms;

   modport source (output valid, opcode, device_id, channel_kind, period_ms, input ready);
   modport sink   (input valid, opcode, device_id, channel_kind, period_ms, output ready);
endinterface

`default_nettype wire

@@ rtl/pps_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Poll scheduler response channel
// Valid/ready channel carrying add status and poll request transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface pps_rsp_if;
   import pps_pkg::*;

   logic              valid;
   logic              ready;
   logic              result_kind;
   logic [1:0]        add_status;
   logic [DEV_W-1:0]  request_device;
   logic [KIND_W-1:0] request_channel;
   logic              group_last;
   logic              tick_last;

   modport source (output valid, result_kind, add_status, request_device, request_channel,
                   group_last, tick_last, input ready);
   modport sink   (input valid, result_kind, add_status, request_device, request_channel,
                   group_last, tick_last, output ready);
endinterface

`default_nettype wire

@@ rtl/pps_divider.sv @@
// ----------------------------------------------------------------------------
// Poll scheduler period divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [pps_pkg::PERIOD_W-1:0]   dividend,
   input  wire logic [pps_pkg::STEP_W-1:0]     divisor,
   output logic                                done,
   output logic [pps_pkg::PERIOD_W-1:0]        quotient
);
   import pps_pkg::*;

   localparam int CNT_W = $clog2(PERIOD_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [STEP_W-1:0]   div_ff, div_in;
   logic [STEP_W-1:0]   rem_ff, rem_in;
   logic [PERIOD_W-1:0] quo_ff, quo_in;
   logic [STEP_W:0]     shifted;
   logic [STEP_W:0]     div_x;
   logic                ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[PERIOD_W-1]};
      div_x   = {1'b0, div_ff};
      ge      = (shifted >= div_x);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(PERIOD_W);
         div_in  = divisor;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? STEP_W'(shifted - div_x) : STEP_W'(shifted);
         quo_in = {quo_ff[PERIOD_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ rtl/pps_table.sv @@
// ----------------------------------------------------------------------------
// Poll scheduler channel table
// Single-port-read, single-port-write entry memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_table #(
   parameter int DEPTH = pps_pkg::MAX_CHANNELS_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output pps_pkg::entry_type                           rd_data,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire pps_pkg::entry_type                      wr_data
);
   import pps_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/periodic_poll_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// Periodic poll scheduler
// Channel table with add/duplicate checking and tick-driven grouped polling.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Handshake       Carries
//   req_bus   in   valid/ready     opcode, device_id, channel_kind, period_ms
//   rsp_bus   out  valid/ready     add status or one poll request element
//   csr_*     in   write enable    step_time_ms
//
// Sequence: an add reads the stored entries for the duplicate scan, then runs
// the period divider; a tick counts every entry down, scans the table, and
// rescans the whole table for each expired group. Every one of these table
// reads goes through the single read port.
// Reset clears the entry count and control state; table contents need no clear.
// A full output register stalls the scan in place until the transaction is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_poll_scheduler_top #(
   parameter int MAX_CHANNELS = pps_pkg::MAX_CHANNELS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   pps_req_if.sink                            req_bus,
   pps_rsp_if.source                          rsp_bus,
   input  wire logic                          csr_wr_en,
   input  wire logic [pps_pkg::STEP_W-1:0]    csr_wr_data
);
   import pps_pkg::*;

   localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DUP_RD,
      S_DUP_EV,
      S_DIV_GO,
      S_DIV_WAIT,
      S_ADD_DONE,
      S_DEC_RD,
      S_DEC_WR,
      S_SCAN_RD,
      S_SCAN_EV,
      S_IN_RD,
      S_IN_EV,
      S_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    jdx_ff, jdx_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [DEV_W-1:0]    dev_ff, dev_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [PERIOD_W-1:0] pms_ff, pms_in;
   add_status_type      status_ff, status_in;
   logic [DEV_W-1:0]    grp_dev_ff, grp_dev_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [KIND_W-1:0]   pend_kind_ff, pend_kind_in;
   logic                pend_last_ff, pend_last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_ff, rsp_in;

   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   entry_type           rd_data;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   entry_type           wr_data;

   logic                div_start;
   logic                div_done;
   logic [PERIOD_W-1:0] div_quot;
   logic [STEP_W-1:0]   divisor;
   logic [PERIOD_W-1:0] period;

   logic                out_free;
   logic                hit;
   logic [CNT_W-1:0]    idx_next;
   logic [CNT_W-1:0]    jdx_next;

   pps_table #(
      .DEPTH (MAX_CHANNELS)
   ) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // A step of zero divides as one
   assign divisor = (step_ff == '0) ? STEP_W'(1) : step_ff;

   pps_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (pms_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Period is at least one tick
   assign period   = (div_quot == '0) ? PERIOD_W'(1) : div_quot;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign idx_next = idx_ff + CNT_W'(1);
   assign jdx_next = jdx_ff + CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      jdx_in        = jdx_ff;
      step_in       = csr_wr_en ? csr_wr_data : step_ff;
      dev_in        = dev_ff;
      kind_in       = kind_ff;
      pms_in        = pms_ff;
      status_in     = status_ff;
      grp_dev_in    = grp_dev_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_last_in  = pend_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = rd_data;
      div_start     = 1'b0;
      hit           = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               dev_in  = req_bus.device_id;
               kind_in = req_bus.channel_kind;
               pms_in  = req_bus.period_ms;
               idx_in  = '0;
               jdx_in  = '0;
               if (req_bus.opcode == OP_ADD) begin
                  if (cnt_ff == CNT_W'(MAX_CHANNELS)) begin
                     status_in = ADD_FULL;
                     state_in  = S_ADD_DONE;
                  end else if (cnt_ff == '0) begin
                     state_in = S_DIV_GO;
                  end else begin
                     state_in = S_DUP_RD;
                  end
               end else if (cnt_ff != '0) begin
                  state_in = S_DEC_RD;
               end
            end
         end

         S_DUP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = jdx_ff[IDX_W-1:0];
            state_in = S_DUP_EV;
         end

         S_DUP_EV: begin
            if (rd_data.device == dev_ff && rd_data.kind == kind_ff) begin
               status_in = ADD_DUP;
               state_in  = S_ADD_DONE;
            end else begin
               jdx_in   = jdx_next;
               state_in = (jdx_next == cnt_ff) ? S_DIV_GO : S_DUP_RD;
            end
         end

         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end

         S_DIV_WAIT: begin
            if (div_done) begin
               wr_en             = 1'b1;
               wr_addr           = cnt_ff[IDX_W-1:0];
               wr_data.device    = dev_ff;
               wr_data.kind      = kind_ff;
               wr_data.period    = period;
               wr_data.countdown = period;
               cnt_in            = cnt_ff + CNT_W'(1);
               status_in         = ADD_OK;
               state_in          = S_ADD_DONE;
            end
         end

         S_ADD_DONE: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.result_kind     = RES_ADD;
               rsp_in.add_status      = status_ff;
               rsp_in.request_device  = '0;
               rsp_in.request_channel = '0;
               rsp_in.group_last      = 1'b0;
               rsp_in.tick_last       = 1'b0;
               state_in               = S_IDLE;
            end
         end

         // Count every entry down by one
         S_DEC_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff[IDX_W-1:0];
            state_in = S_DEC_WR;
         end

         S_DEC_WR: begin
            wr_en             = 1'b1;
            wr_addr           = idx_ff[IDX_W-1:0];
            wr_data.countdown = rd_data.countdown - PERIOD_W'(1);
            if (idx_next == cnt_ff) begin
               idx_in   = '0;
               state_in = S_SCAN_RD;
            end else begin
               idx_in   = idx_next;
               state_in = S_DEC_RD;
            end
         end

         // Outer scan: find the entry that opens the next group
         S_SCAN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff[IDX_W-1:0];
            state_in = S_SCAN_EV;
         end

         S_SCAN_EV: begin
            if (rd_data.countdown == '0) begin
               if (!pend_valid_ff || out_free) begin
                  wr_en             = 1'b1;
                  wr_addr           = idx_ff[IDX_W-1:0];
                  wr_data.countdown = rd_data.period;
                  grp_dev_in        = rd_data.device;
                  if (pend_valid_ff) begin
                     rsp_valid_in           = 1'b1;
                     rsp_in.result_kind     = RES_POLL;
                     rsp_in.add_status      = ADD_OK;
                     rsp_in.request_device  = grp_dev_ff;
                     rsp_in.request_channel = pend_kind_ff;
                     rsp_in.group_last      = pend_last_ff;
                     rsp_in.tick_last       = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_kind_in  = rd_data.kind;
                  pend_last_in  = 1'b0;
                  jdx_in        = '0;
                  state_in      = S_IN_RD;
               end
            end else begin
               idx_in   = idx_next;
               state_in = (idx_next == cnt_ff) ? S_FINISH : S_SCAN_RD;
            end
         end

         // Inner scan: gather the other expired entries of the same device
         S_IN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = jdx_ff[IDX_W-1:0];
            state_in = S_IN_EV;
         end

         S_IN_EV: begin
            hit = (rd_data.countdown == '0) && (rd_data.device == grp_dev_ff);
            if (!hit || out_free) begin
               if (hit) begin
                  wr_en                  = 1'b1;
                  wr_addr                = jdx_ff[IDX_W-1:0];
                  wr_data.countdown      = rd_data.period;
                  rsp_valid_in           = 1'b1;
                  rsp_in.result_kind     = RES_POLL;
                  rsp_in.add_status      = ADD_OK;
                  rsp_in.request_device  = grp_dev_ff;
                  rsp_in.request_channel = pend_kind_ff;
                  rsp_in.group_last      = pend_last_ff;
                  rsp_in.tick_last       = 1'b0;
                  pend_kind_in           = rd_data.kind;
                  pend_last_in           = 1'b0;
               end
               if (jdx_next == cnt_ff) begin
                  // Group closes on the element held back
                  pend_last_in = 1'b1;
                  idx_in       = idx_next;
                  state_in     = (idx_next == cnt_ff) ? S_FINISH : S_SCAN_RD;
               end else begin
                  jdx_in   = jdx_next;
                  state_in = S_IN_RD;
               end
            end
         end

         S_FINISH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.result_kind     = RES_POLL;
               rsp_in.add_status      = ADD_OK;
               rsp_in.request_device  = grp_dev_ff;
               rsp_in.request_channel = pend_kind_ff;
               rsp_in.group_last      = pend_last_ff;
               rsp_in.tick_last       = 1'b1;
               pend_valid_in          = 1'b0;
               state_in               = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         step_ff       <= STEP_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         step_ff       <= step_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      jdx_ff       <= jdx_in;
      dev_ff       <= dev_in;
      kind_ff      <= kind_in;
      pms_ff       <= pms_in;
      status_ff    <= status_in;
      grp_dev_ff   <= grp_dev_in;
      pend_kind_ff <= pend_kind_in;
      pend_last_ff <= pend_last_in;
      rsp_ff       <= rsp_in;
   end

   assign req_bus.ready           = (state_ff == S_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.result_kind     = rsp_ff.result_kind;
   assign rsp_bus.add_status      = rsp_ff.add_status;
   assign rsp_bus.request_device  = rsp_ff.request_device;
   assign rsp_bus.request_channel = rsp_ff.request_channel;
   assign rsp_bus.group_last      = rsp_ff.group_last;
   assign rsp_bus.tick_last       = rsp_ff.tick_last;

endmodule

`default_nettype wire

@@ rtl/pps_checker.sv @@
// ----------------------------------------------------------------------------
// Poll scheduler port checker
// Watches the top-level ports and flags response and sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_ready,
   input  wire logic                       req_opcode,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire logic                       result_kind,
   input  wire logic [1:0]                 add_status,
   input  wire logic [pps_pkg::DEV_W-1:0]  request_device,
   input  wire logic [pps_pkg::KIND_W-1:0] request_channel,
   input  wire logic                       group_last,
   input  wire logic                       tick_last
);
   import pps_pkg::*;

   // Hold a stalled transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_kind) && $stable(add_status)
         && $stable(request_device) && $stable(request_channel)
         && $stable(group_last) && $stable(tick_last))
      else $error("response changed while stalled");

   // Add status results carry a legal code and no request fields
   a_add_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && result_kind == RES_ADD |->
         (add_status == ADD_OK || add_status == ADD_FULL || add_status == ADD_DUP)
         && request_device == '0 && request_channel == '0 && !group_last && !tick_last)
      else $error("malformed add status result");

   // Last result of a tick also closes its group
   a_tick_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && result_kind == RES_POLL |-> add_status == ADD_OK
         && (!tick_last || group_last))
      else $error("malformed poll request element");

   // An add transaction keeps the request side busy until its status is queued
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode == OP_ADD |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind periodic_poll_scheduler_top pps_checker u_pps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_opcode      (req_bus.opcode),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .result_kind     (rsp_bus.result_kind),
   .add_status      (rsp_bus.add_status),
   .request_device  (rsp_bus.request_device),
   .request_channel (rsp_bus.request_channel),
   .group_last      (rsp_bus.group_last),
   .tick_last       (rsp_bus.tick_last)
);

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// Periodic poll scheduler testbench
// Drives add and tick transactions with random gaps, and keeps a shadow channel
// table that predicts every add status and poll request. Each result is
// compared field by field in arrival order. The step time is reprogrammed
// between phases, and the table is filled to capacity before the last phase.
// ----------------------------------------------------------------------------

module testbench;
   import pps_pkg::*;

   localparam int SLOTS       = MAX_CHANNELS_DEF;
   localparam int STALL_LIMIT = 40000;  // well above the longest idle pause
   localparam int PHASE_ITEMS = 24;

   typedef struct packed {
      logic                opcode;
      logic [DEV_W-1:0]    device_id;
      logic [KIND_W-1:0]   channel_kind;
      logic [PERIOD_W-1:0] period_ms;
   } poll_cmd_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [STEP_W-1:0]   csr_wr_data;

   pps_req_if req_bus ();
   pps_rsp_if rsp_bus ();

   periodic_poll_scheduler_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the channel table and the step register
   logic [STEP_W-1:0]   step_shadow;
   int                  shadow_count;
   logic [DEV_W-1:0]    chan_device    [SLOTS];
   logic [KIND_W-1:0]   chan_kind      [SLOTS];
   logic [PERIOD_W-1:0] chan_period    [SLOTS];
   logic [PERIOD_W-1:0] chan_countdown [SLOTS];

   rsp_item_type        due_results [$];   // results predicted but not yet seen
   poll_cmd_type        cmd_backlog [$];   // transactions waiting for the driver
   logic [DEV_W+KIND_W-1:0] known_pairs [$];  // every pair ever offered for adding
   logic [DEV_W-1:0]    device_pool [4];
   logic [STEP_W-1:0]   gen_step;

   // Handshake bookkeeping shared between the clocked blocks
   logic req_took = 1'b0;
   logic rsp_took = 1'b0;
   bit   req_busy = 1'b0;
   int   req_gap = 0, rsp_gap = 0;
   int   req_calm = 0, rsp_calm = 0;
   int   idle_cycles = 0;

   int fault_count = 0;
   int n_added = 0, n_full = 0, n_dup = 0, n_ticks = 0, n_polls = 0, n_groups = 0;

   // Free-running clock, period 10
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Draw the number of idle cycles before the next transaction. Now and then
   // open a calm stretch with no idling at all.
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(8, 24);
         return 0;
      end
      return $urandom_range(0, 7);
   endfunction

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fault_count++;
      end
   endfunction

   // Apply one accepted transaction to the shadow table and queue the results
   // it must produce.
   task automatic update_poll_table(input poll_cmd_type cmd);
      rsp_item_type        status;
      rsp_item_type        poll;
      rsp_item_type        burst [SLOTS];
      int unsigned         divisor;
      int unsigned         per;
      logic [DEV_W-1:0]    grp_dev;
      bit                  dup;
      int                  k;
      if (cmd.opcode == OP_ADD) begin
         status             = '0;
         status.result_kind = RES_ADD;
         status.add_status  = ADD_OK;
         dup = 1'b0;
         for (int i = 0; i < shadow_count; i++)
            if (chan_device[i] == cmd.device_id && chan_kind[i] == cmd.channel_kind)
               dup = 1'b1;
         // Fullness wins over a duplicate pair
         if (shadow_count >= SLOTS) begin
            status.add_status = ADD_FULL;
            n_full++;
         end else if (dup) begin
            status.add_status = ADD_DUP;
            n_dup++;
         end else begin
            // A zero step counts as one millisecond; the period is at least one tick
            divisor = (step_shadow == '0) ? 1 : step_shadow;
            per     = cmd.period_ms / divisor;
            if (per == 0)
               per = 1;
            chan_device[shadow_count]    = cmd.device_id;
            chan_kind[shadow_count]      = cmd.channel_kind;
            chan_period[shadow_count]    = per;
            chan_countdown[shadow_count] = per;
            shadow_count++;
            n_added++;
         end
         due_results.push_back(status);
      end else begin
         n_ticks++;
         k = 0;
         for (int i = 0; i < shadow_count; i++)
            chan_countdown[i] = chan_countdown[i] - 1;
         // Every expired entry below i has already been reloaded, so a group
         // started at i gathers the same device from i upward.
         for (int i = 0; i < shadow_count; i++) begin
            if (chan_countdown[i] == 0) begin
               grp_dev = chan_device[i];
               for (int j = i; j < shadow_count; j++) begin
                  if (chan_countdown[j] == 0 && chan_device[j] == grp_dev) begin
                     chan_countdown[j]    = chan_period[j];
                     poll                 = '0;
                     poll.result_kind     = RES_POLL;
                     poll.add_status      = ADD_OK;
                     poll.request_device  = grp_dev;
                     poll.request_channel = chan_kind[j];
                     burst[k] = poll;
                     k++;
                  end
               end
               burst[k-1].group_last = 1'b1;
               n_groups++;
            end
         end
         if (k > 0)
            burst[k-1].tick_last = 1'b1;
         for (int i = 0; i < k; i++)
            due_results.push_back(burst[i]);
         n_polls += k;
      end
   endtask

   // Monitor: sample both channels at the rising edge, predict on every
   // accepted request, check every accepted result against the oldest
   // prediction.
   always @(posedge clock) begin
      rsp_item_type want;
      req_took <= !reset && req_bus.valid === 1'b1 && req_bus.ready === 1'b1;
      rsp_took <= !reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1;
      if (reset) begin
         step_shadow  = STEP_RESET;
         shadow_count = 0;
      end else begin
         if (csr_wr_en)
            step_shadow = csr_wr_data;
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            update_poll_table({req_bus.opcode, req_bus.device_id,
                               req_bus.channel_kind, req_bus.period_ms});
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (due_results.size() == 0) begin
               $error("unexpected result transaction: result_kind %0d device %0d channel %0d",
                      rsp_bus.result_kind, rsp_bus.request_device, rsp_bus.request_channel);
               fault_count++;
            end else begin
               want = due_results.pop_front();
               check_field("result_kind", want.result_kind, rsp_bus.result_kind);
               check_field("add_status", want.add_status, rsp_bus.add_status);
               check_field("request_device", want.request_device, rsp_bus.request_device);
               check_field("request_channel", want.request_channel, rsp_bus.request_channel);
               check_field("group_last", want.group_last, rsp_bus.group_last);
               check_field("tick_last", want.tick_last, rsp_bus.tick_last);
            end
         end
      end
   end

   // Driver: on the falling edge, retire the transaction taken at the last
   // rising edge, hold valid low for the drawn gap, then present the next one.
   always @(negedge clock) begin
      poll_cmd_type cmd;
      if (req_took) begin
         req_busy = 1'b0;
         req_gap  = draw_gap(req_calm);
      end
      if (!req_busy) begin
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (cmd_backlog.size() > 0) begin
            cmd = cmd_backlog.pop_front();
            req_bus.opcode       <= cmd.opcode;
            req_bus.device_id    <= cmd.device_id;
            req_bus.channel_kind <= cmd.channel_kind;
            req_bus.period_ms    <= cmd.period_ms;
            req_bus.valid        <= 1'b1;
            req_busy = 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result sink: after each taken result, drop ready for the drawn number
   // of cycles, then raise it again.
   always @(negedge clock) begin
      if (rsp_took)
         rsp_gap = draw_gap(rsp_calm);
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Watchdog: end the run when no transaction moves on either channel for
   // too long.
   always @(posedge clock) begin
      if (reset || req_took || rsp_took) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, due_results.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic queue_add(input logic [DEV_W-1:0] dev, input logic [KIND_W-1:0] kind,
                            input logic [PERIOD_W-1:0] pms);
      cmd_backlog.push_back({OP_ADD, dev, kind, pms});
      known_pairs.push_back({dev, kind});
   endtask

   // Ticks carry random content in the unused fields
   task automatic queue_tick();
      cmd_backlog.push_back({OP_TICK, DEV_W'($urandom), KIND_W'($urandom),
                             PERIOD_W'($urandom)});
   endtask

   // Wait until every transaction is sent and every result is in, then give a
   // tick that raises nothing time to finish its scan.
   task automatic drain_and_pause();
      while (cmd_backlog.size() != 0 || req_busy || due_results.size() != 0)
         @(posedge clock);
      repeat (2 * shadow_count * shadow_count + 4 * shadow_count + 64) @(posedge clock);
   endtask

   task automatic write_step(input logic [STEP_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      gen_step = value;
   endtask

   // Mostly ticks and well-formed adds on a small device pool so that groups
   // form; the rest re-offers known pairs or sends fully random adds.
   task automatic random_phase(input int count);
      int                      roll;
      int unsigned             eff;
      logic [DEV_W+KIND_W-1:0] pair;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         eff  = (gen_step == '0) ? 1 : gen_step;
         if (roll < 55) begin
            queue_tick();
         end else if (roll < 62 && known_pairs.size() > 0) begin
            pair = known_pairs[$urandom_range(0, known_pairs.size() - 1)];
            queue_add(pair[DEV_W+KIND_W-1:KIND_W], pair[KIND_W-1:0], $urandom);
         end else if (roll < 68) begin
            queue_add(DEV_W'($urandom), KIND_W'($urandom), $urandom);
         end else begin
            queue_add(device_pool[$urandom_range(0, 3)], KIND_W'($urandom),
                      eff * $urandom_range(1, 6) + $urandom_range(0, eff - 1));
         end
      end
   endtask

   initial begin
      int                 need;
      int unsigned        eff;
      bit                 clash;
      logic [DEV_W-1:0]   dev;
      logic [KIND_W-1:0]  kind_try;

      // Known values on every input from time zero
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_bus.valid        = 1'b0;
      req_bus.opcode       = OP_ADD;
      req_bus.device_id    = '0;
      req_bus.channel_kind = '0;
      req_bus.period_ms    = '0;
      rsp_bus.ready        = 1'b0;
      gen_step             = STEP_RESET;
      for (int i = 0; i < 4; i++)
         device_pool[i] = DEV_W'($urandom);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset step of 1000 ms.
      // Tick on an empty table: nothing expires, nothing comes back.
      queue_tick();
      queue_add(8'd0,   8'd0,   32'd0);           // zero period rounds up to one tick
      queue_add(8'd0,   8'd1,   32'd999);         // below one step, also one tick
      queue_add(8'd255, 8'd255, 32'hFFFF_FFFF);   // longest period, never fires here
      queue_add(8'd0,   8'd0,   32'd5000);        // same pair again: duplicate
      queue_add(8'd255, 8'd0,   32'd2000);
      queue_add(8'd0,   8'd255, 32'd2999);
      queue_add(8'd255, 8'd1,   32'd3000);
      // Device 0 fires every tick; device 255 joins in on the 2- and 3-tick
      // entries, so groups of both devices interleave in the table.
      repeat (6) queue_tick();
      queue_add(8'hA5, 8'h5A, 32'h5A5A_5A5A);
      queue_add(8'h5A, 8'hA5, 32'hA5A5_A5A5);
      queue_tick();

      // Step of zero behaves as one millisecond
      drain_and_pause();
      write_step('0);
      random_phase(PHASE_ITEMS);

      // Largest step
      drain_and_pause();
      write_step('1);
      random_phase(PHASE_ITEMS);

      // Smallest legal step
      drain_and_pause();
      write_step(16'd1);
      random_phase(PHASE_ITEMS);

      // Random step; fill the table to capacity with fresh pairs, then
      // confirm that adds are refused, a known pair included.
      drain_and_pause();
      write_step(STEP_W'($urandom_range(1, 65535)));
      eff      = (gen_step == '0) ? 1 : gen_step;
      need     = SLOTS - shadow_count;
      kind_try = KIND_W'($urandom);
      while (need > 0) begin
         dev   = device_pool[$urandom_range(0, 3)];
         clash = 1'b0;
         for (int i = 0; i < shadow_count; i++)
            if (chan_device[i] == dev && chan_kind[i] == kind_try)
               clash = 1'b1;
         if (!clash) begin
            queue_add(dev, kind_try, eff * $urandom_range(2, 8));
            need--;
         end
         kind_try++;
      end
      queue_add(chan_device[0], chan_kind[0], 32'd0);
      queue_add(DEV_W'($urandom), KIND_W'($urandom), $urandom);
      random_phase(PHASE_ITEMS);

      drain_and_pause();
      $display("Covered %0d adds (%0d stored, %0d refused full, %0d duplicate), %0d ticks.",
               n_added + n_full + n_dup, n_added, n_full, n_dup, n_ticks);
      $display("Ticks raised %0d poll requests in %0d device groups; %0d faults seen.",
               n_polls, n_groups, fault_count);
      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
